FILE: hdl/bhfp_pkg.sv
// Shared types, constants and helper functions for the bitmap header field parser.
package bhfp_pkg;

    localparam int DATA_W  = 8;
    localparam int TDATA_W = 168;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BITMAP2,
        PH_FIELD,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_ESP     = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_TRUNC   = 2'd3
    } t_kind;

    // Header field indexes, in wire order; also the bit positions of the present flags.
    localparam logic [2:0] FLD_VERSION  = 3'd0;
    localparam logic [2:0] FLD_DEST     = 3'd1;
    localparam logic [2:0] FLD_LENGTH   = 3'd2;
    localparam logic [2:0] FLD_TTL      = 3'd3;
    localparam logic [2:0] FLD_FLOW     = 3'd4;
    localparam logic [2:0] FLD_SRC      = 3'd5;
    localparam logic [2:0] FLD_PROTOCOL = 3'd6;
    localparam logic [2:0] FLD_CHECKSUM = 3'd7;

    // First bitmap byte.
    localparam int BM1_CONT    = 7;
    localparam int BM1_ESP     = 6;
    localparam int BM1_VERSION = 5;
    localparam int BM1_DEST_HI = 4;
    localparam int BM1_DEST_LO = 3;
    localparam int BM1_LENGTH  = 2;
    localparam int BM1_TTL     = 1;
    localparam int BM1_FLOW    = 0;

    // Second bitmap byte.
    localparam int BM2_SRC_HI   = 6;
    localparam int BM2_SRC_LO   = 5;
    localparam int BM2_PROTOCOL = 4;
    localparam int BM2_CHECKSUM = 3;

    // Address size codes.
    localparam logic [1:0] ADDR_NONE  = 2'd0;
    localparam logic [1:0] ADDR_SHORT = 2'd1;
    localparam logic [1:0] ADDR_WORD  = 2'd2;
    localparam logic [1:0] ADDR_LONG  = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  present;
        logic [7:0]  version_value;
        logic [31:0] dest_address;
        logic [15:0] length_value;
        logic [7:0]  ttl_value;
        logic [31:0] flow_value;
        logic [31:0] src_address;
        logic [7:0]  protocol_value;
        logic [15:0] checksum_value;
        logic [7:0]  payload_data;
        logic        payload_last;
    } t_result;

    function automatic logic [4:0] code_bytes(input logic [1:0] code);
        logic [4:0] n;
        unique case (code)
            ADDR_SHORT: n = 5'd2;
            ADDR_WORD:  n = 5'd4;
            ADDR_LONG:  n = 5'd16;
            default:    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] field_size(input logic [2:0] k, input logic [1:0] dcode,
                                              input logic [1:0] scode);
        logic [4:0] n;
        unique case (k)
            FLD_VERSION:  n = 5'd1;
            FLD_DEST:     n = code_bytes(dcode);
            FLD_LENGTH:   n = 5'd2;
            FLD_TTL:      n = 5'd1;
            FLD_FLOW:     n = 5'd4;
            FLD_SRC:      n = code_bytes(scode);
            FLD_PROTOCOL: n = 5'd1;
            default:      n = 5'd2;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/bhfp_in_reg.sv
// Input register: holds one accepted byte until the parse stage takes it.
module bhfp_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  bhfp_pkg::t_item    i_item,
    input  logic               i_take,
    output logic               o_valid,
    output bhfp_pkg::t_item    o_item
);

    logic            r_valid;
    bhfp_pkg::t_item r_item;
    logic            w_accept;

    assign o_tready = !r_valid || i_take;
    assign w_accept = i_tvalid && o_tready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hdl/bhfp_parse.sv
// Parse stage: packet state registers and the per-byte header decode.
module bhfp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  bhfp_pkg::t_item    i_item,
    output logic               o_emit,
    output bhfp_pkg::t_result  o_res
);

    bhfp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [4:0]  r_count, n_count;
    logic [7:0]  r_flags, n_flags;
    logic [1:0]  r_dcode, n_dcode;
    logic [1:0]  r_scode, n_scode;
    logic [7:0]  r_version, n_version;
    logic [31:0] r_dest, n_dest;
    logic [15:0] r_length, n_length;
    logic [7:0]  r_ttl, n_ttl;
    logic [31:0] r_flow, n_flow;
    logic [31:0] r_src, n_src;
    logic [7:0]  r_protocol, n_protocol;
    logic [15:0] r_checksum, n_checksum;

    logic [7:0]  w_b;
    logic        w_first;
    logic        w_last;
    logic        w_take;
    logic [7:0]  w_flags;
    logic [4:0]  w_cnt_inc;
    logic        w_field_done;
    logic [3:0]  w_start;
    logic [7:0]  w_masked;
    logic [2:0]  w_found_idx;
    logic        w_found;
    logic        w_adv;
    logic        w_emit;
    bhfp_pkg::t_kind w_kind;

    assign w_b     = i_item.data;
    assign w_first = i_item.first;
    assign w_last  = i_item.last;
    assign w_take  = !w_first && (r_phase == bhfp_pkg::PH_FIELD);

    assign w_cnt_inc    = r_count + 5'd1;
    assign w_field_done = w_cnt_inc >= bhfp_pkg::field_size(r_idx, r_dcode, r_scode);

    // Present flags as they stand once this byte's bitmap bits are decoded.
    always_comb begin
        w_flags = r_flags;
        if (w_first) begin
            w_flags = '0;
            w_flags[bhfp_pkg::FLD_VERSION] = w_b[bhfp_pkg::BM1_VERSION];
            w_flags[bhfp_pkg::FLD_DEST]    = w_b[bhfp_pkg::BM1_DEST_HI] |
                                             w_b[bhfp_pkg::BM1_DEST_LO];
            w_flags[bhfp_pkg::FLD_LENGTH]  = w_b[bhfp_pkg::BM1_LENGTH];
            w_flags[bhfp_pkg::FLD_TTL]     = w_b[bhfp_pkg::BM1_TTL];
            w_flags[bhfp_pkg::FLD_FLOW]    = w_b[bhfp_pkg::BM1_FLOW];
        end else if (r_phase == bhfp_pkg::PH_BITMAP2) begin
            w_flags[bhfp_pkg::FLD_SRC]      = w_b[bhfp_pkg::BM2_SRC_HI] |
                                              w_b[bhfp_pkg::BM2_SRC_LO];
            w_flags[bhfp_pkg::FLD_PROTOCOL] = w_b[bhfp_pkg::BM2_PROTOCOL];
            w_flags[bhfp_pkg::FLD_CHECKSUM] = w_b[bhfp_pkg::BM2_CHECKSUM];
        end
    end

    // Search for the next present field at or after the start index.
    assign w_start  = w_take ? ({1'b0, r_idx} + 4'd1) : 4'd0;
    assign w_masked = w_flags & (8'hFF << w_start);
    assign w_found  = |w_masked;

    always_comb begin
        w_found_idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (w_masked[i]) begin
                w_found_idx = 3'(i);
            end
        end
    end

    // Field value capture, big-endian.
    always_comb begin
        n_version  = r_version;
        n_dest     = r_dest;
        n_length   = r_length;
        n_ttl      = r_ttl;
        n_flow     = r_flow;
        n_src      = r_src;
        n_protocol = r_protocol;
        n_checksum = r_checksum;
        if (w_first) begin
            n_version  = '0;
            n_dest     = '0;
            n_length   = '0;
            n_ttl      = '0;
            n_flow     = '0;
            n_src      = '0;
            n_protocol = '0;
            n_checksum = '0;
        end else if (w_take) begin
            unique case (r_idx)
                bhfp_pkg::FLD_VERSION:  n_version = w_b;
                bhfp_pkg::FLD_DEST: begin
                    if (r_dcode != bhfp_pkg::ADDR_LONG) begin
                        n_dest = {r_dest[23:0], w_b};
                    end
                end
                bhfp_pkg::FLD_LENGTH:   n_length = {r_length[7:0], w_b};
                bhfp_pkg::FLD_TTL:      n_ttl = w_b;
                bhfp_pkg::FLD_FLOW:     n_flow = {r_flow[23:0], w_b};
                bhfp_pkg::FLD_SRC: begin
                    if (r_scode != bhfp_pkg::ADDR_LONG) begin
                        n_src = {r_src[23:0], w_b};
                    end
                end
                bhfp_pkg::FLD_PROTOCOL: n_protocol = w_b;
                default:                n_checksum = {r_checksum[7:0], w_b};
            endcase
        end
    end

    // Next state of the packet walk.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_count = r_count;
        n_flags = r_flags;
        n_dcode = r_dcode;
        n_scode = r_scode;
        w_adv   = 1'b0;
        w_emit  = 1'b0;
        w_kind  = bhfp_pkg::KIND_HEADER;
        if (w_first) begin
            n_count = '0;
            n_scode = '0;
            if (w_b[bhfp_pkg::BM1_ESP]) begin
                n_flags = '0;
                n_dcode = '0;
                n_phase = bhfp_pkg::PH_IDLE;
                w_emit  = 1'b1;
                w_kind  = bhfp_pkg::KIND_ESP;
            end else begin
                n_flags = w_flags;
                n_dcode = w_b[bhfp_pkg::BM1_DEST_HI:bhfp_pkg::BM1_DEST_LO];
                if (w_b[bhfp_pkg::BM1_CONT]) begin
                    n_phase = w_last ? bhfp_pkg::PH_IDLE : bhfp_pkg::PH_BITMAP2;
                    w_emit  = w_last;
                    w_kind  = bhfp_pkg::KIND_TRUNC;
                end else begin
                    w_adv = 1'b1;
                end
            end
        end else begin
            unique case (r_phase)
                bhfp_pkg::PH_BITMAP2: begin
                    n_scode = w_b[bhfp_pkg::BM2_SRC_HI:bhfp_pkg::BM2_SRC_LO];
                    n_flags = w_flags;
                    w_adv   = 1'b1;
                end
                bhfp_pkg::PH_FIELD: begin
                    n_count = w_cnt_inc;
                    if (w_field_done) begin
                        w_adv = 1'b1;
                    end else if (w_last) begin
                        n_phase = bhfp_pkg::PH_IDLE;
                        w_emit  = 1'b1;
                        w_kind  = bhfp_pkg::KIND_TRUNC;
                    end
                end
                bhfp_pkg::PH_PAYLOAD: begin
                    w_emit = 1'b1;
                    w_kind = bhfp_pkg::KIND_PAYLOAD;
                    if (w_last) begin
                        n_phase = bhfp_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = bhfp_pkg::PH_IDLE;
                end
            endcase
        end
        if (w_adv) begin
            if (!w_found) begin
                // Header complete: report it with the byte just taken.
                w_emit  = 1'b1;
                w_kind  = bhfp_pkg::KIND_HEADER;
                n_phase = w_last ? bhfp_pkg::PH_IDLE : bhfp_pkg::PH_PAYLOAD;
            end else begin
                n_idx   = w_found_idx;
                n_count = '0;
                n_phase = w_last ? bhfp_pkg::PH_IDLE : bhfp_pkg::PH_FIELD;
                w_emit  = w_last;
                w_kind  = bhfp_pkg::KIND_TRUNC;
            end
        end
    end

    // Result fields: whatever does not belong to the kind stays zero.
    always_comb begin
        o_res      = '0;
        o_res.kind = w_kind;
        if (w_kind == bhfp_pkg::KIND_HEADER || w_kind == bhfp_pkg::KIND_TRUNC) begin
            o_res.present = n_flags;
        end
        if (w_kind == bhfp_pkg::KIND_HEADER) begin
            o_res.version_value  = n_version;
            o_res.dest_address   = n_dest;
            o_res.length_value   = n_length;
            o_res.ttl_value      = n_ttl;
            o_res.flow_value     = n_flow;
            o_res.src_address    = n_src;
            o_res.protocol_value = n_protocol;
            o_res.checksum_value = n_checksum;
        end
        if (w_kind == bhfp_pkg::KIND_PAYLOAD) begin
            o_res.payload_data = w_b;
            o_res.payload_last = w_last;
        end
    end

    assign o_emit = w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bhfp_pkg::PH_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_flags <= '0;
            r_dcode <= '0;
            r_scode <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_flags <= n_flags;
            r_dcode <= n_dcode;
            r_scode <= n_scode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_version  <= n_version;
            r_dest     <= n_dest;
            r_length   <= n_length;
            r_ttl      <= n_ttl;
            r_flow     <= n_flow;
            r_src      <= n_src;
            r_protocol <= n_protocol;
            r_checksum <= n_checksum;
        end
    end

`ifndef ASSERT_OFF
    a_esp_on_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_emit && o_res.kind == bhfp_pkg::KIND_ESP) |-> i_item.first)
        else $error("ESP result without a first byte");

    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_emit && o_res.kind == bhfp_pkg::KIND_PAYLOAD)
            |-> (r_phase == bhfp_pkg::PH_PAYLOAD && !i_item.first))
        else $error("payload result outside the payload phase");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.last) |=> (r_phase == bhfp_pkg::PH_IDLE))
        else $error("parser not idle after the last byte of a packet");

    a_trunc_no_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_res.kind == bhfp_pkg::KIND_TRUNC)
            |-> (o_res.dest_address == '0 && o_res.flow_value == '0 &&
                 o_res.src_address == '0))
        else $error("truncated-header result carries field values");
`endif

endmodule

FILE: hdl/bhfp_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module bhfp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_emit,
    input  bhfp_pkg::t_result  i_res,
    input  logic               i_tready,
    output logic               o_tvalid,
    output bhfp_pkg::t_result  o_res,
    output logic               o_can_load
);

    logic              r_valid;
    bhfp_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_tready;
    assign o_tvalid   = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_emit;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: hdl/bitmap_header_field_parser_core.sv
// A byte sits in the input register, then its result in the result register.
// Throughput: one byte per cycle unless a result waits for the downstream side;
// one result register and one input register let a new byte enter meanwhile.
// Reset: synchronous, active low; clears both handshake stages and returns the
// parser to idle, so bytes before the next first byte give no result.
module bitmap_header_field_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bhfp_pkg::DATA_W-1:0]    s_axis_tdata,   // data_byte
    input  logic                           s_axis_tuser,   // first_byte
    input  logic                           s_axis_tlast,   // last_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // present, version_value, dest_address, length_value, ttl_value, flow_value,
    // src_address, protocol_value, checksum_value, payload_data
    output logic [bhfp_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [bhfp_pkg::TUSER_W-1:0]   m_axis_tuser,   // kind
    output logic                           m_axis_tlast    // payload_last
);

    bhfp_pkg::t_item   w_in_item;
    bhfp_pkg::t_item   w_item;
    logic              w_item_valid;
    logic              w_can_load;
    logic              w_take;
    logic              w_emit;
    bhfp_pkg::t_result w_res;
    bhfp_pkg::t_result w_out;

    assign w_in_item.data  = s_axis_tdata;
    assign w_in_item.first = s_axis_tuser;
    assign w_in_item.last  = s_axis_tlast;

    assign w_take = w_item_valid && w_can_load;

    bhfp_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_item   (w_in_item),
        .i_take   (w_take),
        .o_valid  (w_item_valid),
        .o_item   (w_item)
    );

    bhfp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_take),
        .i_item  (w_item),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    bhfp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take),
        .i_emit     (w_emit),
        .i_res      (w_res),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_res      (w_out),
        .o_can_load (w_can_load)
    );

    assign m_axis_tdata = {w_out.payload_data, w_out.checksum_value, w_out.protocol_value,
                           w_out.src_address, w_out.flow_value, w_out.ttl_value,
                           w_out.length_value, w_out.dest_address, w_out.version_value,
                           w_out.present};
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.payload_last;

endmodule

FILE: tb/bitmap_header_field_parser_core_tb.sv
// Self-checking testbench that streams packets into the header parser and checks each result.
`timescale 1ns / 1ps

module bitmap_header_field_parser_core_tb;

    localparam int STALL_LIMIT = 2000;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [bhfp_pkg::DATA_W-1:0]    s_axis_tdata  = '0;     // data_byte
    logic                           s_axis_tuser  = 1'b0;   // first_byte
    logic                           s_axis_tlast  = 1'b0;   // last_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // present, version_value, dest_address, length_value, ttl_value, flow_value,
    // src_address, protocol_value, checksum_value, payload_data
    logic [bhfp_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [bhfp_pkg::TUSER_W-1:0]   m_axis_tuser;           // kind
    logic                           m_axis_tlast;           // payload_last

    bitmap_header_field_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bhfp_pkg::t_item   tx_bytes[$];
    bhfp_pkg::t_item   tx_next;
    bhfp_pkg::t_item   rx_item;
    bhfp_pkg::t_result pending_results[$];
    bhfp_pkg::t_result parsed;
    int      send_idle_pct = 14;
    int      recv_idle_pct = 69;
    int      fail_count    = 0;
    int      stall_cycles  = 0;

    // Parser state as the block should hold it.
    bhfp_pkg::t_phase  ps_phase = bhfp_pkg::PH_IDLE;
    logic [2:0]        ps_field = '0;
    logic [4:0]        ps_count = '0;
    logic [7:0]        ps_flags = '0;
    logic [1:0]        ps_dcode = '0;
    logic [1:0]        ps_scode = '0;
    bhfp_pkg::t_result ps_vals  = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int addr_bytes(input logic [1:0] code);
        return (code == bhfp_pkg::ADDR_LONG) ? 16 : 2 * int'(code);
    endfunction

    function automatic int field_bytes(input int k, input logic [1:0] dcode,
                                       input logic [1:0] scode);
        case (k)
            bhfp_pkg::FLD_DEST:     return addr_bytes(dcode);
            bhfp_pkg::FLD_SRC:      return addr_bytes(scode);
            bhfp_pkg::FLD_LENGTH,
            bhfp_pkg::FLD_CHECKSUM: return 2;
            bhfp_pkg::FLD_FLOW:     return 4;
            default:                return 1;
        endcase
    endfunction

    function automatic bhfp_pkg::t_result truncated_result();
        bhfp_pkg::t_result res;
        res = '0;
        res.kind = bhfp_pkg::KIND_TRUNC;
        res.present = ps_flags;
        ps_phase = bhfp_pkg::PH_IDLE;
        return res;
    endfunction

    // Skips to the next present field; the header is complete when none is left.
    function automatic bit next_field(input int start, input bit last,
                                      output bhfp_pkg::t_result res);
        int k;
        k = start;
        res = '0;
        while (k < 8 && !ps_flags[k])
            k++;
        if (k >= 8) begin
            res = ps_vals;
            res.kind = bhfp_pkg::KIND_HEADER;
            res.present = ps_flags;
            ps_phase = last ? bhfp_pkg::PH_IDLE : bhfp_pkg::PH_PAYLOAD;
            return 1'b1;
        end
        ps_phase = bhfp_pkg::PH_FIELD;
        ps_field = k[2:0];
        ps_count = '0;
        if (last) begin
            res = truncated_result();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input bhfp_pkg::t_item it,
                                      output bhfp_pkg::t_result res);
        bit done;
        done = 1'b0;
        res = '0;
        if (it.first) begin
            ps_flags = '0;
            ps_count = '0;
            ps_dcode = bhfp_pkg::ADDR_NONE;
            ps_scode = bhfp_pkg::ADDR_NONE;
            ps_vals = '0;
            if (it.data[bhfp_pkg::BM1_ESP]) begin
                res.kind = bhfp_pkg::KIND_ESP;
                ps_phase = bhfp_pkg::PH_IDLE;
                done = 1'b1;
            end else begin
                ps_dcode = it.data[bhfp_pkg::BM1_DEST_HI:bhfp_pkg::BM1_DEST_LO];
                ps_flags[bhfp_pkg::FLD_VERSION] = it.data[bhfp_pkg::BM1_VERSION];
                ps_flags[bhfp_pkg::FLD_DEST] = (ps_dcode != bhfp_pkg::ADDR_NONE);
                ps_flags[bhfp_pkg::FLD_LENGTH] = it.data[bhfp_pkg::BM1_LENGTH];
                ps_flags[bhfp_pkg::FLD_TTL] = it.data[bhfp_pkg::BM1_TTL];
                ps_flags[bhfp_pkg::FLD_FLOW] = it.data[bhfp_pkg::BM1_FLOW];
                if (it.data[bhfp_pkg::BM1_CONT]) begin
                    ps_phase = bhfp_pkg::PH_BITMAP2;
                    if (it.last) begin
                        res = truncated_result();
                        done = 1'b1;
                    end
                end else begin
                    done = next_field(0, it.last, res);
                end
            end
        end else begin
            case (ps_phase)
                bhfp_pkg::PH_BITMAP2: begin
                    ps_scode = it.data[bhfp_pkg::BM2_SRC_HI:bhfp_pkg::BM2_SRC_LO];
                    ps_flags[bhfp_pkg::FLD_SRC] = (ps_scode != bhfp_pkg::ADDR_NONE);
                    ps_flags[bhfp_pkg::FLD_PROTOCOL] = it.data[bhfp_pkg::BM2_PROTOCOL];
                    ps_flags[bhfp_pkg::FLD_CHECKSUM] = it.data[bhfp_pkg::BM2_CHECKSUM];
                    done = next_field(0, it.last, res);
                end
                bhfp_pkg::PH_FIELD: begin
                    case (ps_field)
                        bhfp_pkg::FLD_VERSION: ps_vals.version_value = it.data;
                        bhfp_pkg::FLD_DEST: begin
                            // Long addresses are consumed but reported as zero.
                            if (ps_dcode != bhfp_pkg::ADDR_LONG)
                                ps_vals.dest_address = {ps_vals.dest_address[23:0], it.data};
                        end
                        bhfp_pkg::FLD_LENGTH:
                            ps_vals.length_value = {ps_vals.length_value[7:0], it.data};
                        bhfp_pkg::FLD_TTL: ps_vals.ttl_value = it.data;
                        bhfp_pkg::FLD_FLOW:
                            ps_vals.flow_value = {ps_vals.flow_value[23:0], it.data};
                        bhfp_pkg::FLD_SRC: begin
                            if (ps_scode != bhfp_pkg::ADDR_LONG)
                                ps_vals.src_address = {ps_vals.src_address[23:0], it.data};
                        end
                        bhfp_pkg::FLD_PROTOCOL: ps_vals.protocol_value = it.data;
                        default:
                            ps_vals.checksum_value = {ps_vals.checksum_value[7:0], it.data};
                    endcase
                    ps_count = ps_count + 5'd1;
                    if (int'(ps_count) >= field_bytes(int'(ps_field), ps_dcode, ps_scode)) begin
                        done = next_field(int'(ps_field) + 1, it.last, res);
                    end else if (it.last) begin
                        res = truncated_result();
                        done = 1'b1;
                    end
                end
                bhfp_pkg::PH_PAYLOAD: begin
                    res.kind = bhfp_pkg::KIND_PAYLOAD;
                    res.payload_data = it.data;
                    res.payload_last = it.last;
                    if (it.last)
                        ps_phase = bhfp_pkg::PH_IDLE;
                    done = 1'b1;
                end
                default: ps_phase = bhfp_pkg::PH_IDLE;
            endcase
        end
        return done;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        bhfp_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d", m_axis_tuser);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
            check_field("present", 32'(want.present), 32'(m_axis_tdata[7:0]));
            check_field("version_value", 32'(want.version_value), 32'(m_axis_tdata[15:8]));
            check_field("dest_address", want.dest_address, m_axis_tdata[47:16]);
            check_field("length_value", 32'(want.length_value), 32'(m_axis_tdata[63:48]));
            check_field("ttl_value", 32'(want.ttl_value), 32'(m_axis_tdata[71:64]));
            check_field("flow_value", want.flow_value, m_axis_tdata[103:72]);
            check_field("src_address", want.src_address, m_axis_tdata[135:104]);
            check_field("protocol_value", 32'(want.protocol_value),
                        32'(m_axis_tdata[143:136]));
            check_field("checksum_value", 32'(want.checksum_value),
                        32'(m_axis_tdata[159:144]));
            check_field("payload_data", 32'(want.payload_data), 32'(m_axis_tdata[167:160]));
            check_field("payload_last", 32'(want.payload_last), 32'(m_axis_tlast));
        end
    endtask

    // Driver: presents queued bytes, and randomly withholds valid and ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    tx_next = tx_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= tx_next.data;
                    s_axis_tuser <= tx_next.first;
                    s_axis_tlast <= tx_next.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks outgoing results first, then predicts from the accepted byte.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready) begin
                rx_item.data = s_axis_tdata;
                rx_item.first = s_axis_tuser;
                rx_item.last = s_axis_tlast;
                if (parse_byte(rx_item, parsed))
                    pending_results.push_back(parsed);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void put_byte(input logic [7:0] d, input logic f, input logic l);
        bhfp_pkg::t_item it;
        it.data = d;
        it.first = f;
        it.last = l;
        tx_bytes.push_back(it);
    endfunction

    // One packet with random content: mostly well formed, some cut short or restarted.
    task automatic add_packet(output int n_items);
        logic [7:0] bm1;
        logic [7:0] bm2;
        logic [7:0] flags;
        logic [7:0] pkt[$];
        logic [1:0] dcode;
        logic [1:0] scode;
        int         hdr_len;
        int         len;
        int         style;
        int         tail;
        bit         ends;
        bm1 = 8'($urandom);
        bm2 = 8'($urandom);
        n_items = 0;
        if ($urandom_range(9, 0) != 0)
            bm1[bhfp_pkg::BM1_ESP] = 1'b0;
        if (bm1[bhfp_pkg::BM1_ESP]) begin
            tail = $urandom_range(3, 0);
            put_byte(bm1, 1'b1, tail == 0);
            for (int i = 1; i <= tail; i++)
                put_byte(8'($urandom), 1'b0, i == tail);
            n_items = 1;
            return;
        end
        pkt.push_back(bm1);
        if (bm1[bhfp_pkg::BM1_CONT])
            pkt.push_back(bm2);
        else
            bm2 = '0;
        dcode = bm1[bhfp_pkg::BM1_DEST_HI:bhfp_pkg::BM1_DEST_LO];
        scode = bm2[bhfp_pkg::BM2_SRC_HI:bhfp_pkg::BM2_SRC_LO];
        flags = {bm2[bhfp_pkg::BM2_CHECKSUM], bm2[bhfp_pkg::BM2_PROTOCOL],
                 scode != bhfp_pkg::ADDR_NONE, bm1[bhfp_pkg::BM1_FLOW],
                 bm1[bhfp_pkg::BM1_TTL], bm1[bhfp_pkg::BM1_LENGTH],
                 dcode != bhfp_pkg::ADDR_NONE, bm1[bhfp_pkg::BM1_VERSION]};
        for (int k = 0; k < 8; k++) begin
            if (flags[k]) begin
                for (int j = 0; j < field_bytes(k, dcode, scode); j++)
                    pkt.push_back(8'($urandom));
            end
        end
        hdr_len = pkt.size();
        repeat ($urandom_range(5, 0))
            pkt.push_back(8'($urandom));
        len = pkt.size();
        ends = 1'b1;
        style = $urandom_range(19, 0);
        if (style < 2 && hdr_len > 1) begin
            len = $urandom_range(hdr_len - 1, 1);
        end else if (style == 2) begin
            len = $urandom_range(pkt.size(), 1);
            ends = 1'b0;
        end
        for (int i = 0; i < len; i++)
            put_byte(pkt[i], i == 0, ends && i == len - 1);
        n_items = len;
        // Stray bytes between packets, which the block should drop.
        if (ends && $urandom_range(9, 0) == 0) begin
            repeat ($urandom_range(2, 1))
                put_byte(8'($urandom), 1'b0, 1'($urandom_range(1, 0)));
        end
    endtask

    task automatic add_random_packets(input int target);
        int total;
        int n;
        total = 0;
        while (total < target) begin
            add_packet(n);
            total += n;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (tx_bytes.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bitmap with nothing present, first and last on one byte.
        put_byte(8'h00, 1'b1, 1'b1);
        // ESP packet with a trailing byte that must be ignored.
        put_byte(8'h40, 1'b1, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b1);
        // Two bitmaps: short destination, TTL, short source, protocol, checksum,
        // then a single payload byte.
        put_byte(8'h8A, 1'b1, 1'b0);
        put_byte(8'h38, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++)
            put_byte(8'hFF, 1'b0, 1'b0);
        put_byte(8'hA5, 1'b0, 1'b1);
        // Header cut off inside the flow field.
        put_byte(8'h21, 1'b1, 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b1);
        // Continuation bit set on a one-byte packet.
        put_byte(8'h80, 1'b1, 1'b1);
        // A new first byte abandons a length field halfway through.
        put_byte(8'h04, 1'b1, 1'b0);
        put_byte(8'h12, 1'b0, 1'b0);
        put_byte(8'h00, 1'b1, 1'b1);
        // Byte while idle.
        put_byte(8'h55, 1'b0, 1'b0);
        // Header-only packet ending on its last version byte.
        put_byte(8'h20, 1'b1, 1'b0);
        put_byte(8'h7F, 1'b0, 1'b1);

        add_random_packets(617);
        wait_drained();
        send_idle_pct = 69;
        recv_idle_pct = 14;
        add_random_packets(617);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_packets(616);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bhfp_pkg.sv
hdl/bhfp_in_reg.sv
hdl/bhfp_parse.sv
hdl/bhfp_out_reg.sv
hdl/bitmap_header_field_parser_core.sv
tb/bitmap_header_field_parser_core_tb.sv
